// ===== rtl/core/itf_pkg.sv =====
// Shared types, character codes and the digit lookup for the integer to text formatter.
// Used by itf_div_unit and integer_to_text_formatter_top. No dependencies.
`default_nettype none

package itf_pkg;

  // Radix codes as they arrive on the input beat; the unused code reads as decimal
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2
  } itf_radix_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LAYOUT,
    ST_BOUND,
    ST_EMIT
  } itf_state_e;

  // floor(x / 10) == (x * DecRecip) >> DecShift for every 32-bit x
  localparam logic [31:0] DecRecip = 32'hCCCC_CCCD;
  localparam int unsigned DecShift = 35;

  // Widest text before padding: sign, two prefix characters, 31 minimum digits
  localparam int unsigned MaxContent = 34;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowX  = 8'h78;

  function automatic logic [7:0] digit_char(logic [3:0] digit, logic upper);
    logic [7:0] ch;
    if (digit < 4'd10) begin
      ch = ChZero + {4'd0, digit};
    end else if (upper) begin
      ch = ChUpA + {4'd0, digit} - 8'd10;
    end else begin
      ch = ChLowA + {4'd0, digit} - 8'd10;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itf_div_unit.sv =====
// Shared divide unit: quotient and remainder of a 32-bit magnitude by 10, 16 or 8.
// Per digit: reciprocal product registered, then correction. Uses itf_pkg.
`default_nettype none

module itf_div_unit (
  input  wire logic                  clk_i,
  input  wire logic [31:0]           mag_i,
  input  wire itf_pkg::itf_radix_e   radix_i,
  output logic      [31:0]           quot_o,
  output logic      [3:0]            rem_o
);

  logic [63:0] prod_q;
  logic [63:0] prod_d;
  logic [31:0] quot_dec;
  logic [31:0] quot_x10;
  logic [31:0] rem_dec;

  // Operand holds across the product and correction cycles
  assign prod_d = {32'd0, mag_i} * {32'd0, itf_pkg::DecRecip};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign quot_dec = 32'(prod_q >> itf_pkg::DecShift);
  assign quot_x10 = (quot_dec << 3) + (quot_dec << 1);
  assign rem_dec  = mag_i - quot_x10;

  always_comb begin
    case (radix_i)
      itf_pkg::RADIX_HEX: begin
        quot_o = mag_i >> 4;
        rem_o  = mag_i[3:0];
      end
      itf_pkg::RADIX_OCT: begin
        quot_o = mag_i >> 3;
        rem_o  = {1'b0, mag_i[2:0]};
      end
      default: begin
        quot_o = quot_dec;
        rem_o  = rem_dec[3:0];
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/integer_to_text_formatter_top.sv =====
// Integer to text formatter, top level: printf-style conversion of one 32-bit value.
// Depends on itf_pkg and itf_div_unit.
//
// Usage
//   Input channel (in_valid_i / in_stall_o): one beat carries the value and all of
//   its formatting flags. A beat is taken only while the block is idle; in_stall_o
//   stays high from the accepting edge until the final character has been loaded
//   into the output register.
//   Output channel (out_valid_o / out_stall_i): one beat per ASCII character, most
//   significant text first; last_char_o marks the final character of the number.
//   Timing: after acceptance each digit passes through the shared divide unit
//   (reciprocal product, then correction), 1 to 11 digits; the layout and bound
//   states set out the sign, prefix, padding and digit boundaries; then one
//   character leaves per cycle while the receiver does not stall.
//   Stalls: a stalled character holds in the output register and the emitter waits;
//   a new value may be accepted while the final character still waits to be taken.
//   Reset: asynchronous, active low; returns to idle and drops any pending character.
`default_nettype none

module integer_to_text_formatter_top #(
  parameter int unsigned MAX_FIELD_WIDTH = 32,
  parameter int unsigned DIGIT_SLOTS     = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] value_i,
  input  wire logic [1:0]  radix_i,
  input  wire logic        signed_mode_i,
  input  wire logic        upper_case_i,
  input  wire logic        left_justify_i,
  input  wire logic        zero_pad_i,
  input  wire logic        plus_sign_i,
  input  wire logic        space_sign_i,
  input  wire logic        alt_form_i,
  input  wire logic [4:0]  min_digits_i,
  input  wire logic [5:0]  text_width_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [7:0]  out_char_o,
  output logic             last_char_o
);

  // Text positions must cover the capped width and the widest unpadded text
  localparam int unsigned PosMax = (MAX_FIELD_WIDTH > itf_pkg::MaxContent) ?
                                   MAX_FIELD_WIDTH : itf_pkg::MaxContent;
  localparam int unsigned PosW   = $clog2(PosMax + 1);
  localparam int unsigned SlackW = PosW + 2;
  localparam int unsigned DigW   = $clog2(DIGIT_SLOTS);
  localparam int unsigned CntW   = $clog2(DIGIT_SLOTS + 1);

  itf_pkg::itf_state_e state_q, state_d;

  // Captured beat
  logic [31:0]         mag_q;
  itf_pkg::itf_radix_e base_q;
  logic                upper_q;
  logic                left_q;
  logic                zpad_q;
  logic                has_sign_q;
  logic [7:0]          sign_char_q;
  logic [1:0]          pfx_len_q;
  logic [4:0]          md_q;
  logic [PosW-1:0]     fw_q;

  // Digit store, least significant digit first
  logic [3:0]          dig_mem [DIGIT_SLOTS];
  logic [CntW-1:0]     n_q;

  // Layout
  logic [PosW-1:0]     prec_q, prec_d;
  logic [PosW-1:0]     pad_q, pad_d;
  logic [PosW-1:0]     b_lead_q, b_sign_q, b_pfx_q, b_zero_q, b_dig_q, b_total_q;
  logic [PosW-1:0]     pos_q;

  // Output register
  logic                out_valid_q;
  logic [7:0]          out_char_q;
  logic                out_last_q;

  logic                accept;
  logic                digit_step;
  logic                emit_load;
  logic                emit_adv;

  // Capture-side decode
  itf_pkg::itf_radix_e in_base;
  logic                in_neg;
  logic [1:0]          in_pfx_len;
  logic [PosW-1:0]     in_fw;

  // Divide unit
  logic [31:0]         div_quot;
  logic [3:0]          div_rem;
  logic                div_done;

  // Layout and emit datapath
  logic [PosW-1:0]     n_ext;
  logic [PosW-1:0]     md_ext;
  logic signed [SlackW-1:0] slack;
  logic [PosW-1:0]     lead_len;
  logic [PosW-1:0]     zero_len;
  logic [PosW-1:0]     trail_len;
  logic [PosW-1:0]     b_lead_d, b_sign_d, b_pfx_d, b_zero_d, b_dig_d, b_total_d;
  logic [PosW-1:0]     pos_inc;
  logic [PosW-1:0]     dig_idx;
  logic                emit_last;
  logic [7:0]          emit_char;

  // ---------------------------------------------------------------------------
  // Capture decode
  // ---------------------------------------------------------------------------
  always_comb begin
    case (radix_i)
      itf_pkg::RADIX_HEX: in_base = itf_pkg::RADIX_HEX;
      itf_pkg::RADIX_OCT: in_base = itf_pkg::RADIX_OCT;
      default:            in_base = itf_pkg::RADIX_DEC;
    endcase
  end

  assign in_neg = signed_mode_i & value_i[31];

  always_comb begin
    in_pfx_len = 2'd0;
    if (alt_form_i) begin
      case (in_base)
        itf_pkg::RADIX_HEX: in_pfx_len = 2'd2;
        itf_pkg::RADIX_OCT: in_pfx_len = 2'd1;
        default:            in_pfx_len = 2'd0;
      endcase
    end
  end

  // Cap the field width
  assign in_fw = ({1'b0, text_width_i} > 7'(MAX_FIELD_WIDTH)) ?
                 PosW'(MAX_FIELD_WIDTH) : PosW'(text_width_i);

  // ---------------------------------------------------------------------------
  // Shared divide unit
  // ---------------------------------------------------------------------------
  itf_div_unit u_div (
    .clk_i   (clk_i),
    .mag_i   (mag_q),
    .radix_i (base_q),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  assign div_done = (div_quot == 32'd0) || (n_q == CntW'(DIGIT_SLOTS - 1));

  // ---------------------------------------------------------------------------
  // Layout: precision, padding, then segment boundaries
  // ---------------------------------------------------------------------------
  assign n_ext  = PosW'(n_q);
  assign md_ext = PosW'(md_q);
  assign prec_d = (md_ext > n_ext) ? md_ext : n_ext;
  assign slack  = $signed(SlackW'(fw_q)) - $signed(SlackW'(pfx_len_q))
                - $signed(SlackW'(prec_d)) - $signed(SlackW'(has_sign_q));
  assign pad_d  = slack[SlackW-1] ? '0 : slack[PosW-1:0];

  // Spaces lead unless zero padding or left justification is in force
  assign lead_len  = (!zpad_q && !left_q) ? pad_q : '0;
  assign zero_len  = (zpad_q ? pad_q : '0) + (prec_q - n_ext);
  assign trail_len = left_q ? pad_q : '0;

  assign b_lead_d  = lead_len;
  assign b_sign_d  = b_lead_d + PosW'(has_sign_q);
  assign b_pfx_d   = b_sign_d + PosW'(pfx_len_q);
  assign b_zero_d  = b_pfx_d + zero_len;
  assign b_dig_d   = b_zero_d + n_ext;
  assign b_total_d = b_dig_d + trail_len;

  // ---------------------------------------------------------------------------
  // Character selection by text position
  // ---------------------------------------------------------------------------
  assign pos_inc   = pos_q + PosW'(1);
  assign emit_last = (pos_inc == b_total_q);
  assign dig_idx   = b_dig_q - pos_q - PosW'(1);

  always_comb begin
    if (pos_q < b_lead_q) begin
      emit_char = itf_pkg::ChSpace;
    end else if (pos_q < b_sign_q) begin
      emit_char = sign_char_q;
    end else if (pos_q < b_pfx_q) begin
      if (pos_q == b_sign_q) begin
        emit_char = itf_pkg::ChZero;
      end else begin
        emit_char = upper_q ? itf_pkg::ChUpX : itf_pkg::ChLowX;
      end
    end else if (pos_q < b_zero_q) begin
      emit_char = itf_pkg::ChZero;
    end else if (pos_q < b_dig_q) begin
      emit_char = itf_pkg::digit_char(dig_mem[DigW'(dig_idx)], upper_q);
    end else begin
      emit_char = itf_pkg::ChSpace;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign emit_adv = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    digit_step = 1'b0;
    emit_load  = 1'b0;
    case (state_q)
      itf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = itf_pkg::ST_MUL;
        end
      end
      itf_pkg::ST_MUL: begin
        state_d = itf_pkg::ST_DIV;
      end
      itf_pkg::ST_DIV: begin
        digit_step = 1'b1;
        state_d    = div_done ? itf_pkg::ST_LAYOUT : itf_pkg::ST_MUL;
      end
      itf_pkg::ST_LAYOUT: begin
        state_d = itf_pkg::ST_BOUND;
      end
      itf_pkg::ST_BOUND: begin
        state_d = itf_pkg::ST_EMIT;
      end
      itf_pkg::ST_EMIT: begin
        if (emit_adv) begin
          emit_load = 1'b1;
          if (emit_last) begin
            state_d = itf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = itf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the beat; take the magnitude of a negative signed value
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q       <= in_neg ? (32'd0 - value_i) : value_i;
      base_q      <= in_base;
      upper_q     <= upper_case_i;
      left_q      <= left_justify_i;
      zpad_q      <= zero_pad_i & ~left_justify_i;
      has_sign_q  <= signed_mode_i & (value_i[31] | plus_sign_i | space_sign_i);
      sign_char_q <= in_neg ? itf_pkg::ChMinus :
                     (plus_sign_i ? itf_pkg::ChPlus : itf_pkg::ChSpace);
      pfx_len_q   <= in_pfx_len;
      md_q        <= min_digits_i;
      fw_q        <= in_fw;
    end else if (digit_step) begin
      mag_q <= div_quot;
    end
  end

  // Store one digit per divide step
  always_ff @(posedge clk_i) begin
    if (digit_step) begin
      dig_mem[DigW'(n_q)] <= div_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q <= '0;
    end else if (digit_step) begin
      n_q <= n_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == itf_pkg::ST_LAYOUT) begin
      prec_q <= prec_d;
      pad_q  <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == itf_pkg::ST_BOUND) begin
      b_lead_q  <= b_lead_d;
      b_sign_q  <= b_sign_d;
      b_pfx_q   <= b_pfx_d;
      b_zero_q  <= b_zero_d;
      b_dig_q   <= b_dig_d;
      b_total_q <= b_total_d;
    end
  end

  // Advance the text position once per loaded character
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= '0;
    end else if (emit_load) begin
      pos_q <= pos_inc;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, drop valid once taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

endmodule

`default_nettype wire
